// ===== rtl/core/vnrc_pkg.sv =====
// Shared types, constants and helpers of the voxel neighbour rank counter.
`timescale 1ns / 1ps

package vnrc_pkg;

    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 1024;

    localparam int VOX_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int CX_W     = 6;
    localparam int CY_W     = 6;
    localparam int CZ_W     = 10;
    localparam int SIZE_X_W = 7;
    localparam int SIZE_Y_W = 7;
    localparam int SIZE_Z_W = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PART_W   = 4;

    localparam int SIZE_RST = 64;
    localparam int SIZE_MIN = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef logic [VOX_W-1:0] t_vox;
    typedef logic [1:0][VOX_W-1:0] t_plane_word;
    typedef logic [1:0][2:0][VOX_W-1:0] t_line_word;
    typedef logic [2:0][2:0][VOX_W-1:0] t_column;
    typedef logic [2:0][2:0][2:0][VOX_W-1:0] t_cube;

    typedef struct packed {
        logic            produce;
        logic [CX_W-1:0] centre_x;
        logic [CY_W-1:0] centre_y;
        logic [CZ_W-1:0] centre_z;
        logic            last_result;
    } t_meta;

    typedef struct packed {
        logic [COUNT_W-1:0] smaller_count;
        logic [CX_W-1:0]    centre_x;
        logic [CY_W-1:0]    centre_y;
        logic [CZ_W-1:0]    centre_z;
        logic               last_result;
    } t_res;

    function automatic int clamp_size(int v, int hi);
        int r;
        r = v;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/vnrc_in_if.sv =====
// Request channel that carries one voxel value per transfer.
`timescale 1ns / 1ps

interface vnrc_in_if import vnrc_pkg::*; ();
    logic valid;
    logic ready;
    logic [VOX_W-1:0] voxel_value;

    modport source(output valid, output voxel_value, input ready);
    modport sink(input valid, input voxel_value, output ready);
endinterface

// ===== rtl/core/vnrc_out_if.sv =====
// Result channel that carries one neighbour count and its centre position.
`timescale 1ns / 1ps

interface vnrc_out_if import vnrc_pkg::*; ();
    logic valid;
    logic ready;
    logic [COUNT_W-1:0] smaller_count;
    logic [CX_W-1:0] centre_x;
    logic [CY_W-1:0] centre_y;
    logic [CZ_W-1:0] centre_z;
    logic last_result;

    modport source(output valid, output smaller_count, output centre_x, output centre_y,
                   output centre_z, output last_result, input ready);
    modport sink(input valid, input smaller_count, input centre_x, input centre_y,
                 input centre_z, input last_result, output ready);
endinterface

// ===== rtl/core/voxel_neighbour_rank_count.sv =====
// Top level of the voxel neighbour rank counter.
//
// Usage: voxels of a volume arrive on i_vox in raster order, x fastest, then y,
// then z, one request per transfer. For every interior voxel the block returns
// on o_res the number of its 26 neighbours that hold a strictly smaller value,
// with the centre coordinates and a flag on the final interior voxel. A result
// leaves on the request that brings the centre's last neighbour; border voxels
// give no result. The volume size comes from the three size registers written
// on the i_cfg port; any write restarts the raster at the origin.
// Throughput is one request per cycle while i_vox.ready is high; every request
// does one read and one write-back of the plane memory and of the line memory.
// A request crosses the r_s1, window, partial-count and output registers.
// After reset the sizes are 64 (clamped to the parameters) and the raster
// starts at the origin; the history memories are not cleared, since every
// entry a result reads has been written earlier in the same volume.
// When the receiver stalls, a two-entry output buffer keeps requests flowing
// until both entries are full; then i_vox.ready drops and the pipeline holds.

`timescale 1ns / 1ps

module voxel_neighbour_rank_count import vnrc_pkg::*; #(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    vnrc_in_if.sink              i_vox,
    vnrc_out_if.source           o_res
);

    localparam int XW = $clog2(MAX_X);
    localparam int PW = $clog2(MAX_X * MAX_Y);

    logic          en;
    logic          acc;
    t_meta         meta;
    logic [XW-1:0] line_addr;
    logic [PW-1:0] plane_addr;
    logic          win_valid;
    t_meta         win_meta;
    t_cube         win_cube;

    assign i_vox.ready = en;
    assign acc         = i_vox.valid && en;

    vnrc_ctrl #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .o_meta      (meta),
        .o_line_addr (line_addr),
        .o_plane_addr(plane_addr)
    );

    vnrc_window #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_acc       (acc),
        .i_value     (i_vox.voxel_value),
        .i_meta      (meta),
        .i_line_addr (line_addr),
        .i_plane_addr(plane_addr),
        .o_valid     (win_valid),
        .o_meta      (win_meta),
        .o_cube      (win_cube)
    );

    vnrc_rank u_rank (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(win_valid),
        .i_meta (win_meta),
        .i_cube (win_cube),
        .o_ready(en),
        .o_res  (o_res)
    );

endmodule

// ===== rtl/core/vnrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module vnrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/vnrc_ctrl.sv =====
// Size registers, raster position counters and buffer addresses.
`timescale 1ns / 1ps

module vnrc_ctrl import vnrc_pkg::*; #(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z,
    localparam int XW = $clog2(MAX_X),
    localparam int PW = $clog2(MAX_X * MAX_Y)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_acc,
    output t_meta                o_meta,
    output logic [XW-1:0]        o_line_addr,
    output logic [PW-1:0]        o_plane_addr
);

    localparam int YW  = $clog2(MAX_Y);
    localparam int ZW  = $clog2(MAX_Z);
    localparam int SXW = $clog2(MAX_X + 1);
    localparam int SYW = $clog2(MAX_Y + 1);
    localparam int SZW = $clog2(MAX_Z + 1);

    localparam logic [SXW-1:0] SX_RST = SXW'(clamp_size(SIZE_RST, MAX_X));
    localparam logic [SYW-1:0] SY_RST = SYW'(clamp_size(SIZE_RST, MAX_Y));
    localparam logic [SZW-1:0] SZ_RST = SZW'(clamp_size(SIZE_RST, MAX_Z));

    logic [SXW-1:0] r_sx;
    logic [SYW-1:0] r_sy;
    logic [SZW-1:0] r_sz;
    logic [XW-1:0]  r_cx, n_cx;
    logic [YW-1:0]  r_cy, n_cy;
    logic [ZW-1:0]  r_cz, n_cz;
    logic [PW-1:0]  r_pa, n_pa;
    logic x_end, y_end, z_end;

    always_comb begin
        x_end = (SXW'(r_cx) == r_sx - SXW'(1));
        y_end = (SYW'(r_cy) == r_sy - SYW'(1));
        z_end = (SZW'(r_cz) == r_sz - SZW'(1));

        n_cx = x_end ? '0 : r_cx + XW'(1);
        n_cy = r_cy;
        n_cz = r_cz;
        n_pa = r_pa + PW'(1);
        if (x_end) begin
            n_cy = y_end ? '0 : r_cy + YW'(1);
            if (y_end) begin
                n_cz = z_end ? '0 : r_cz + ZW'(1);
                n_pa = '0;
            end
        end

        o_meta.produce     = (r_cx >= XW'(2)) && (r_cy >= YW'(2)) && (r_cz >= ZW'(2));
        o_meta.centre_x    = CX_W'(r_cx - XW'(1));
        o_meta.centre_y    = CY_W'(r_cy - YW'(1));
        o_meta.centre_z    = CZ_W'(r_cz - ZW'(1));
        o_meta.last_result = x_end && y_end && z_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= SX_RST;
            r_sy <= SY_RST;
            r_sz <= SZ_RST;
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_pa <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SIZE_X: begin
                    r_sx <= SXW'(clamp_size(int'(i_cfg_wdata[SIZE_X_W-1:0]), MAX_X));
                end
                REG_SIZE_Y: begin
                    r_sy <= SYW'(clamp_size(int'(i_cfg_wdata[SIZE_Y_W-1:0]), MAX_Y));
                end
                REG_SIZE_Z: begin
                    r_sz <= SZW'(clamp_size(int'(i_cfg_wdata[SIZE_Z_W-1:0]), MAX_Z));
                end
                default: begin
                end
            endcase
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_pa <= '0;
        end else if (i_acc) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
            r_pa <= n_pa;
        end
    end

    assign o_line_addr  = r_cx;
    assign o_plane_addr = r_pa;

endmodule

// ===== rtl/core/vnrc_window.sv =====
// Plane and line history memories with the 3x3x3 neighbourhood window.
`timescale 1ns / 1ps

module vnrc_window import vnrc_pkg::*; #(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    localparam int XW = $clog2(MAX_X),
    localparam int PW = $clog2(MAX_X * MAX_Y)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_acc,
    input  t_vox          i_value,
    input  t_meta         i_meta,
    input  logic [XW-1:0] i_line_addr,
    input  logic [PW-1:0] i_plane_addr,
    output logic          o_valid,
    output t_meta         o_meta,
    output t_cube         o_cube
);

    logic          r_s1_valid;
    t_meta         r_s1_meta;
    t_vox          r_s1_value;
    logic [XW-1:0] r_s1_la;
    logic [PW-1:0] r_s1_pa;
    logic          r_s2_valid;
    t_meta         r_s2_meta;
    t_cube         r_cube;

    t_plane_word plane_rd, plane_wr;
    t_line_word  line_rd, line_wr;
    t_column     col;
    logic        wr_en;

    assign wr_en = i_en && r_s1_valid;

    vnrc_ram #(
        .WIDTH($bits(t_plane_word)),
        .DEPTH(MAX_X * MAX_Y)
    ) u_plane_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_pa),
        .i_wr_data(plane_wr),
        .i_rd_en  (i_acc),
        .i_rd_addr(i_plane_addr),
        .o_rd_data(plane_rd)
    );

    vnrc_ram #(
        .WIDTH($bits(t_line_word)),
        .DEPTH(MAX_X)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_la),
        .i_wr_data(line_wr),
        .i_rd_en  (i_acc),
        .i_rd_addr(i_line_addr),
        .o_rd_data(line_rd)
    );

    // Column entry [dy][dz] is the voxel dy rows and dz planes behind the request.
    always_comb begin
        col[0][0] = r_s1_value;
        col[0][1] = plane_rd[0];
        col[0][2] = plane_rd[1];
        col[1]    = line_rd[0];
        col[2]    = line_rd[1];

        plane_wr[0] = col[0][0];
        plane_wr[1] = col[0][1];
        line_wr[0]  = col[0];
        line_wr[1]  = col[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_meta  <= i_meta;
            r_s1_value <= i_value;
            r_s1_la    <= i_line_addr;
            r_s1_pa    <= i_plane_addr;
        end
        if (wr_en) begin
            r_s2_meta <= r_s1_meta;
            r_cube[2] <= r_cube[1];
            r_cube[1] <= r_cube[0];
            r_cube[0] <= col;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_meta  = r_s2_meta;
    assign o_cube  = r_cube;

endmodule

// ===== rtl/core/vnrc_rank.sv =====
// Neighbour comparison, count reduction and the buffered result output.
`timescale 1ns / 1ps

module vnrc_rank import vnrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_meta             i_meta,
    input  t_cube             i_cube,
    output logic              o_ready,
    vnrc_out_if.source        o_res
);

    logic                           r_s3_valid;
    t_meta                          r_s3_meta;
    logic [2:0][PART_W-1:0]         r_part;
    logic [2:0][PART_W-1:0]         n_part;
    logic                           r_o_valid;
    t_res                           r_o;
    logic                           r_skid_valid;
    t_res                           r_skid;
    t_res                           push_res;
    logic                           push;
    t_vox                           centre;

    // Each plane of the window is counted on its own, the centre itself is skipped.
    always_comb begin
        centre = i_cube[1][1][1];
        for (int dz = 0; dz < 3; dz++) begin
            n_part[dz] = '0;
            for (int dy = 0; dy < 3; dy++) begin
                for (int dx = 0; dx < 3; dx++) begin
                    if (!(dx == 1 && dy == 1 && dz == 1) && (i_cube[dx][dy][dz] < centre)) begin
                        n_part[dz] = n_part[dz] + PART_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        push_res.smaller_count = COUNT_W'(r_part[0]) + COUNT_W'(r_part[1])
                               + COUNT_W'(r_part[2]);
        push_res.centre_x      = r_s3_meta.centre_x;
        push_res.centre_y      = r_s3_meta.centre_y;
        push_res.centre_z      = r_s3_meta.centre_z;
        push_res.last_result   = r_s3_meta.last_result;
        push = i_en && r_s3_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid && i_meta.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_meta <= i_meta;
            r_part    <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_o_valid || o_res.ready) begin
            if (r_skid_valid) begin
                r_o_valid    <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_o_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || o_res.ready) begin
            r_o <= r_skid_valid ? r_skid : push_res;
        end else if (push) begin
            r_skid <= push_res;
        end
    end

    assign o_ready             = !r_skid_valid;
    assign o_res.valid         = r_o_valid;
    assign o_res.smaller_count = r_o.smaller_count;
    assign o_res.centre_x      = r_o.centre_x;
    assign o_res.centre_y      = r_o.centre_y;
    assign o_res.centre_z      = r_o.centre_z;
    assign o_res.last_result   = r_o.last_result;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_o_valid)
        else $error("skid entry held while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && o_res.ready |=> !r_skid_valid && r_o_valid)
        else $error("skid entry not moved to output after a transfer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o.smaller_count <= COUNT_W'(26))
        else $error("neighbour count above 26");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !push)
        else $error("result pushed while skid entry is occupied");

endmodule

// ===== sim/vnrc_count_monitor.sv =====
// Watches the voxel and result channels, predicts each neighbour count and compares.
`timescale 1ns / 1ps

module vnrc_count_monitor import vnrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    vnrc_in_if                   i_vox,
    vnrc_out_if                  i_res,
    output int                   o_mismatches,
    output int                   o_pending
);

    logic [SIZE_X_W-1:0] size_x;
    logic [SIZE_Y_W-1:0] size_y;
    logic [SIZE_Z_W-1:0] size_z;
    int                  column_pos;
    int                  row_pos;
    int                  plane_pos;
    int                  bad_counts;
    t_vox                recent_planes [0:2][0:DEF_MAX_Y-1][0:DEF_MAX_X-1];
    t_res                due_counts [$];

    function automatic int fit_extent(int written, int top);
        return (written < SIZE_MIN) ? SIZE_MIN : ((written > top) ? top : written);
    endfunction

    function void count_smaller_neighbours(t_vox value);
        int   sx;
        int   sy;
        int   sz;
        int   cx;
        int   cy;
        int   cz;
        int   smaller;
        t_vox centre;
        t_res item;
        sx = fit_extent(int'(size_x), DEF_MAX_X);
        sy = fit_extent(int'(size_y), DEF_MAX_Y);
        sz = fit_extent(int'(size_z), DEF_MAX_Z);
        if (column_pos >= sx || row_pos >= sy || plane_pos >= sz) begin
            column_pos = 0;
            row_pos = 0;
            plane_pos = 0;
        end
        cx = column_pos;
        cy = row_pos;
        cz = plane_pos;
        recent_planes[cz % 3][cy][cx] = value;
        if (cx >= 2 && cy >= 2 && cz >= 2) begin
            centre = recent_planes[(cz - 1) % 3][cy - 1][cx - 1];
            smaller = 0;
            for (int dz = 0; dz < 3; dz++) begin
                for (int dy = 0; dy < 3; dy++) begin
                    for (int dx = 0; dx < 3; dx++) begin
                        if (!(dz == 1 && dy == 1 && dx == 1) &&
                            recent_planes[(cz - 2 + dz) % 3][cy - 2 + dy][cx - 2 + dx] < centre) begin
                            smaller++;
                        end
                    end
                end
            end
            item.smaller_count = COUNT_W'(smaller);
            item.centre_x = CX_W'(cx - 1);
            item.centre_y = CY_W'(cy - 1);
            item.centre_z = CZ_W'(cz - 1);
            item.last_result = (cx == sx - 1 && cy == sy - 1 && cz == sz - 1);
            due_counts.push_back(item);
        end
        if (cx + 1 < sx) begin
            column_pos = cx + 1;
        end else begin
            column_pos = 0;
            if (cy + 1 < sy) begin
                row_pos = cy + 1;
            end else begin
                row_pos = 0;
                plane_pos = (cz + 1 < sz) ? cz + 1 : 0;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            size_x = SIZE_X_W'(SIZE_RST);
            size_y = SIZE_Y_W'(SIZE_RST);
            size_z = SIZE_Z_W'(SIZE_RST);
            column_pos = 0;
            row_pos = 0;
            plane_pos = 0;
            bad_counts = 0;
            due_counts.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SIZE_X: size_x = i_cfg_wdata[SIZE_X_W-1:0];
                    REG_SIZE_Y: size_y = i_cfg_wdata[SIZE_Y_W-1:0];
                    REG_SIZE_Z: size_z = i_cfg_wdata[SIZE_Z_W-1:0];
                    default: ;
                endcase
                column_pos = 0;
                row_pos = 0;
                plane_pos = 0;
            end
            if (i_vox.valid && i_vox.ready) begin
                count_smaller_neighbours(i_vox.voxel_value);
            end
            if (i_res.valid && i_res.ready) begin
                got.smaller_count = i_res.smaller_count;
                got.centre_x = i_res.centre_x;
                got.centre_y = i_res.centre_y;
                got.centre_z = i_res.centre_z;
                got.last_result = i_res.last_result;
                if (due_counts.size() == 0) begin
                    bad_counts++;
                    if (bad_counts <= 10) begin
                        $display("Unexpected result: count %0d at (%0d,%0d,%0d) last %0b",
                                 got.smaller_count, got.centre_x, got.centre_y,
                                 got.centre_z, got.last_result);
                    end
                end else begin
                    want = due_counts.pop_front();
                    if (got.smaller_count !== want.smaller_count ||
                        got.centre_x !== want.centre_x || got.centre_y !== want.centre_y ||
                        got.centre_z !== want.centre_z ||
                        got.last_result !== want.last_result) begin
                        bad_counts++;
                        if (bad_counts <= 10) begin
                            $display("Expected count %0d at (%0d,%0d,%0d) last %0b, got %0d at (%0d,%0d,%0d) last %0b",
                                     want.smaller_count, want.centre_x, want.centre_y,
                                     want.centre_z, want.last_result, got.smaller_count,
                                     got.centre_x, got.centre_y, got.centre_z,
                                     got.last_result);
                        end
                    end
                end
            end
        end
        o_mismatches <= bad_counts;
        o_pending <= due_counts.size();
    end

endmodule

// ===== sim/voxel_neighbour_rank_count_test.sv =====
// Top of the voxel neighbour rank counter test: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module voxel_neighbour_rank_count_test;

    import vnrc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 80;

    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_CORNER} t_fill;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    int                   mismatches;
    int                   pending;
    int unsigned          cycle_count = 0;
    int                   sent_total = 0;
    bit                   send_calm = 1'b0;
    bit                   pressure_go = 1'b0;
    bit                   hold_res = 1'b0;

    vnrc_in_if  vox();
    vnrc_out_if res();

    voxel_neighbour_rank_count dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vox       (vox),
        .o_res       (res)
    );

    vnrc_count_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_vox        (vox),
        .i_res        (res),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10) begin
            return 0;
        end else if (r < 14) begin
            return $urandom_range(1, 3);
        end else if (r < 15) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic t_vox fill_value(t_fill fill);
        t_vox v;
        case (fill)
            FILL_WIDE:   v = t_vox'($urandom_range(0, 65535));
            FILL_NARROW: v = t_vox'($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    2: v = 16'h7FFF;
                    3: v = 16'h8000;
                    4: v = 16'h0001;
                    default: v = 16'hFFFE;
                endcase
            end
        endcase
        return v;
    endfunction

    // The receiver stalls at random, with calm stretches and one long hold.
    initial begin
        int gap_left;
        int calm_left;
        bit calm;
        gap_left = 0;
        calm_left = 0;
        calm = 1'b0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                calm_left = 64;
            end
            calm_left--;
            if (hold_res) begin
                res.ready <= 1'b0;
            end else if (gap_left > 0) begin
                res.ready <= 1'b0;
                gap_left--;
            end else begin
                gap_left = calm ? 0 : idle_span();
                if (gap_left > 0) begin
                    res.ready <= 1'b0;
                    gap_left--;
                end else begin
                    res.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_res = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_res = 1'b0;
    end

    task automatic push_voxel(input t_vox value);
        int gap;
        if (sent_total % 50 == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
        end
        gap = send_calm ? 0 : idle_span();
        if (gap > 0) begin
            @(negedge i_clk);
            vox.valid <= 1'b0;
            vox.voxel_value <= t_vox'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        vox.valid <= 1'b1;
        vox.voxel_value <= value;
        do @(posedge i_clk); while (!vox.ready);
        sent_total++;
    endtask

    task automatic send_volume(input int nx, input int ny, input int nz, input t_fill fill,
                               input int stop_at, input int press_at);
        for (int i = 0; i < nx * ny * nz && i < stop_at; i++) begin
            if (i == press_at) begin
                pressure_go = 1'b1;
            end
            push_voxel(fill_value(fill));
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        vox.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int    nx;
        int    ny;
        int    nz;
        int    vols;
        int    total;
        int    stop_at;
        int    random_base;
        t_fill fill;
        t_vox  v;
        vox.valid = 1'b0;
        vox.voxel_value = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_SIZE_X;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two centres: one above all its neighbours, one at the minimum with equal values.
        write_reg(REG_SIZE_X, 4);
        write_reg(REG_SIZE_Y, 3);
        write_reg(REG_SIZE_Z, 3);
        for (int i = 0; i < 36; i++) begin
            case (i % 4)
                0: v = 16'h0000;
                1: v = 16'h7FFF;
                2: v = 16'h8000;
                default: v = 16'h0001;
            endcase
            if (i == 17) begin
                v = 16'hFFFF;
            end else if (i == 18) begin
                v = 16'h0000;
            end
            push_voxel(v);
        end
        wait_idle();

        // Widest line, with oversized x and undersized y writes, and the long receiver hold.
        write_reg(REG_SIZE_X, 127);
        write_reg(REG_SIZE_Y, 1);
        write_reg(REG_SIZE_Z, 3);
        send_volume(64, 3, 3, FILL_WIDE, 64 * 3 * 3, 520);
        wait_idle();

        nx = 64;
        ny = 3;
        nz = 3;
        random_base = sent_total;
        while (sent_total - random_base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                write_reg(REG_SPARE, $urandom);
            end else begin
                nx = $urandom_range(3, 8);
                ny = $urandom_range(3, 8);
                nz = $urandom_range(3, 5);
                if ($urandom_range(0, 7) == 0) begin
                    nx = $urandom_range(9, 24);
                    nz = 3;
                end
                write_reg(REG_SIZE_X, (nx == 3 && $urandom_range(0, 1)) ?
                          $urandom_range(0, 2) : nx);
                write_reg(REG_SIZE_Y, (ny == 3 && $urandom_range(0, 1)) ?
                          $urandom_range(0, 2) : ny);
                write_reg(REG_SIZE_Z, nz);
            end
            fill = t_fill'($urandom_range(0, 2));
            vols = $urandom_range(1, 2);
            total = nx * ny * nz;
            if (total > 2000) begin
                total = 2000;
                vols = 1;
            end
            for (int k = 0; k < vols; k++) begin
                stop_at = total;
                if ($urandom_range(0, 5) == 0) begin
                    stop_at = $urandom_range(1, total - 1);
                end
                if (stop_at > RANDOM_ITEMS - (sent_total - random_base)) begin
                    stop_at = RANDOM_ITEMS - (sent_total - random_base);
                end
                send_volume(nx, ny, nz, fill, stop_at, -1);
                if (stop_at < nx * ny * nz) begin
                    break;
                end
            end
            wait_idle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/vnrc_pkg.sv
rtl/core/vnrc_in_if.sv
rtl/core/vnrc_out_if.sv
rtl/core/vnrc_ram.sv
rtl/core/vnrc_ctrl.sv
rtl/core/vnrc_window.sv
rtl/core/vnrc_rank.sv
rtl/core/voxel_neighbour_rank_count.sv
sim/vnrc_count_monitor.sv
sim/voxel_neighbour_rank_count_test.sv
